### rtl/rau_pkg.sv
// shared types and constants for the rational arithmetic unit
// no dependencies; used by rau_ctrl, rau_dp and rational_arith_unit_core
package rau_pkg;
	localparam int WORD_WIDTH = 32;
	localparam int PROD_W = 2 * WORD_WIDTH;
	localparam int CNT_W = 7;

	typedef enum logic [2:0] {
		KIND_ADD = 3'd0,
		KIND_SUB = 3'd1,
		KIND_MUL = 3'd2,
		KIND_DIV = 3'd3,
		KIND_CMP = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_DIVZ = 2'd1,
		ST_OVF  = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE, S_MUL1, S_MUL2, S_SUM, S_CHK, S_GCD, S_DIVN, S_DIVD, S_FIN, S_OUT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic mul1;
		logic mul2;
		logic sum;
		logic gcd_init;
		logic gcd_step;
		logic div_init;
		logic div_step;
		logic div_sel_d;
		logic fin;
		logic set_err;
		logic set_cmp;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic den_zero;
		logic is_cmp;
		logic d_zero;
		logic gcd_done;
		logic div_done;
	} sts_t;
endpackage

### rtl/rau_ctrl.sv
// control sequencer for the rational arithmetic unit
// depends on rau_pkg
module rau_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  rau_pkg::sts_t sts,
	output rau_pkg::cmd_t cmd
);
	import rau_pkg::*;

	state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = S_MUL1;
				end
			end
			S_MUL1: begin
				if (sts.den_zero) begin
					cmd.set_err = 1'b1;
					state_d = S_OUT;
				end else begin
					cmd.mul1 = 1'b1;
					state_d = S_MUL2;
				end
			end
			S_MUL2: begin
				cmd.mul2 = 1'b1;
				state_d = S_SUM;
			end
			S_SUM: begin
				cmd.sum = 1'b1;
				state_d = S_CHK;
			end
			S_CHK: begin
				if (sts.is_cmp) begin
					cmd.set_cmp = 1'b1;
					state_d = S_OUT;
				end else if (sts.d_zero) begin
					cmd.set_err = 1'b1;
					state_d = S_OUT;
				end else begin
					cmd.gcd_init = 1'b1;
					state_d = S_GCD;
				end
			end
			S_GCD: begin
				if (sts.gcd_done) begin
					cmd.div_init = 1'b1;
					state_d = S_DIVN;
				end else begin
					cmd.gcd_step = 1'b1;
				end
			end
			S_DIVN: begin
				if (sts.div_done) begin
					cmd.div_init = 1'b1;
					cmd.div_sel_d = 1'b1;
					state_d = S_DIVD;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			S_DIVD: begin
				cmd.div_sel_d = 1'b1;
				if (sts.div_done) state_d = S_FIN;
				else cmd.div_step = 1'b1;
			end
			S_FIN: begin
				cmd.fin = 1'b1;
				state_d = S_OUT;
			end
			S_OUT: begin
				out_valid = 1'b1;
				if (out_ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule

### rtl/rau_dp.sv
// datapath: cross products, binary gcd, a restoring divider, result packing
// depends on rau_pkg
module rau_dp (
	input  logic                                  clk,
	input  rau_pkg::cmd_t                         cmd,
	output rau_pkg::sts_t                         sts,
	input  logic [2:0]                            kind,
	input  logic signed [rau_pkg::WORD_WIDTH-1:0] a_num,
	input  logic signed [rau_pkg::WORD_WIDTH-1:0] a_den,
	input  logic signed [rau_pkg::WORD_WIDTH-1:0] b_num,
	input  logic signed [rau_pkg::WORD_WIDTH-1:0] b_den,
	output logic signed [rau_pkg::WORD_WIDTH-1:0] res_num,
	output logic [rau_pkg::WORD_WIDTH-2:0]        res_den,
	output logic signed [1:0]                     order,
	output logic [1:0]                            status
);
	import rau_pkg::*;

	localparam int W = WORD_WIDTH;
	localparam int P = PROD_W;

	// operand registers as sign and magnitude
	logic [2:0] kind_q;
	logic       an_s_q, ad_s_q, bn_s_q, bd_s_q;
	logic [W-1:0] an_m_q, ad_m_q, bn_m_q, bd_m_q;
	logic [P-1:0] p1_q, p2_q, d_q;
	logic         p1_s_q, p2_s_q, d_s_q;
	logic [P-1:0] n_q;
	logic         n_s_q;
	// gcd state
	logic [P-1:0] gx_q, gy_q;
	logic [CNT_W-1:0] gsh_q;
	logic [P-1:0] g_q;
	// divider state
	logic [P-1:0] dq_q, dr_q;
	logic [CNT_W-1:0] dc_q;
	logic [P-1:0] nmq_q;
	// result registers
	logic signed [W-1:0] rnum_q;
	logic [W-2:0] rden_q;
	logic [1:0]   ord_q, stat_q;

	function automatic logic [W-1:0] mag(input logic [W-1:0] v);
		return v[W-1] ? (~v + 1'b1) : v;
	endfunction

	logic [W-1:0] m1a, m1b, m2a, m2b;
	logic [W-1:0] mxa, mxb;
	logic [P-1:0] prod1;
	logic [P:0]   diff;
	logic [P-1:0] gdiff;
	logic [P:0]   trial;
	logic [P-1:0] div_src;

	// operand selection for the single shared multiplier
	always_comb begin
		m1a = an_m_q; m1b = bd_m_q;
		m2a = ad_m_q; m2b = bn_m_q;
		if (kind_q == KIND_MUL) begin
			m1b = bn_m_q; m2b = bd_m_q;
		end
		// denominator product in the sum cycle
		if (cmd.sum) begin
			m2b = bd_m_q;
		end
		mxa = cmd.mul1 ? m1a : m2a;
		mxb = cmd.mul1 ? m1b : m2b;
		prod1 = P'(mxa) * P'(mxb);
	end

	assign diff = {1'b0, p1_q} - {1'b0, p2_q};
	assign gdiff = (gx_q > gy_q) ? (gx_q - gy_q) : (gy_q - gx_q);
	assign div_src = cmd.div_sel_d ? d_q : n_q;
	assign trial = {dr_q[P-2:0], dq_q[P-1]} - {1'b0, g_q};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= kind;
			an_s_q <= a_num[W-1]; an_m_q <= mag(a_num);
			ad_s_q <= a_den[W-1]; ad_m_q <= mag(a_den);
			bn_s_q <= b_num[W-1]; bn_m_q <= mag(b_num);
			bd_s_q <= b_den[W-1]; bd_m_q <= mag(b_den);
		end
		// first product, kept with its sign
		if (cmd.mul1) begin
			p1_q <= prod1;
			p1_s_q <= (prod1 != '0) && (an_s_q != ((kind_q == KIND_MUL) ? bn_s_q : bd_s_q));
		end
		// second product, then denominator
		if (cmd.mul2) begin
			p2_q <= prod1;
			if (kind_q == KIND_MUL)
				p2_s_q <= (prod1 != '0) && (ad_s_q != bd_s_q);
			else
				p2_s_q <= (prod1 != '0) && ((ad_s_q != bn_s_q) ^
					(kind_q == KIND_SUB || kind_q[2]));
		end
		// numerator and denominator per kind
		if (cmd.sum) begin
			d_q <= prod1;
			d_s_q <= ad_s_q != bd_s_q;
			if (kind_q == KIND_MUL) begin
				n_q <= p1_q; n_s_q <= p1_s_q;
				d_q <= p2_q; d_s_q <= (p2_q != '0) && (ad_s_q != bd_s_q);
			end else if (kind_q == KIND_DIV) begin
				n_q <= p1_q; n_s_q <= p1_s_q;
				d_q <= p2_q; d_s_q <= (p2_q != '0) && (ad_s_q != bn_s_q);
			end else if (p1_s_q == p2_s_q) begin
				n_q <= p1_q + p2_q; n_s_q <= p1_s_q;
			end else if (!diff[P]) begin
				n_q <= diff[P-1:0]; n_s_q <= p1_s_q && (diff[P-1:0] != '0);
			end else begin
				n_q <= p2_q - p1_q; n_s_q <= p2_s_q;
			end
		end
		// binary gcd: strip common twos, then subtract
		if (cmd.gcd_init) begin
			gx_q <= n_q; gy_q <= d_q; gsh_q <= '0;
		end else if (cmd.gcd_step) begin
			if (gx_q == '0) begin
				gx_q <= gy_q;
			end else if (!gx_q[0] && !gy_q[0]) begin
				gx_q <= gx_q >> 1; gy_q <= gy_q >> 1; gsh_q <= gsh_q + 1'b1;
			end else if (!gx_q[0]) begin
				gx_q <= gx_q >> 1;
			end else if (!gy_q[0]) begin
				gy_q <= gy_q >> 1;
			end else if (gx_q > gy_q) begin
				gx_q <= gdiff >> 1;
			end else begin
				gy_q <= gdiff >> 1;
			end
		end
		// restoring division, one quotient bit a cycle
		if (cmd.div_init) begin
			if (!cmd.div_sel_d) g_q <= gy_q << gsh_q;
			else nmq_q <= dq_q;
			dq_q <= div_src; dr_q <= '0; dc_q <= '0;
		end else if (cmd.div_step) begin
			dc_q <= dc_q + 1'b1;
			if (!trial[P]) begin
				dr_q <= trial[P-1:0]; dq_q <= {dq_q[P-2:0], 1'b1};
			end else begin
				dr_q <= {dr_q[P-2:0], dq_q[P-1]}; dq_q <= {dq_q[P-2:0], 1'b0};
			end
		end
		if (cmd.set_err) begin
			rnum_q <= '0; rden_q <= '0; ord_q <= '0; stat_q <= ST_DIVZ;
		end
		if (cmd.set_cmp) begin
			rnum_q <= '0; rden_q <= '0; stat_q <= ST_OK;
			if (n_q == '0) ord_q <= 2'b00;
			else if (n_s_q != d_s_q) ord_q <= 2'b11;
			else ord_q <= 2'b01;
		end
		// range check and sign placement
		if (cmd.fin) begin
			ord_q <= '0;
			if (dq_q > P'((64'd1 << (W-1)) - 1) ||
			    ((nmq_q != '0 && n_s_q != d_s_q) ? (nmq_q > P'(64'd1 << (W-1)))
			     : (nmq_q > P'((64'd1 << (W-1)) - 1)))) begin
				rnum_q <= '0; rden_q <= '0; stat_q <= ST_OVF;
			end else begin
				rnum_q <= (nmq_q != '0 && n_s_q != d_s_q) ? W'(~nmq_q + 1'b1)
					: W'(nmq_q);
				rden_q <= dq_q[W-2:0];
				stat_q <= ST_OK;
			end
		end
	end

	logic gcd_zero_fix;
	assign gcd_zero_fix = (gx_q == '0);
	assign sts.den_zero = (ad_m_q == '0) || (bd_m_q == '0);
	assign sts.is_cmp = kind_q[2];
	assign sts.d_zero = (d_q == '0);
	assign sts.gcd_done = gcd_zero_fix || (gx_q == gy_q);
	assign sts.div_done = (dc_q == CNT_W'(P));

	assign res_num = rnum_q;
	assign res_den = rden_q;
	assign order = ord_q;
	assign status = stat_q;
endmodule

### rtl/rational_arith_unit_core.sv
// Rational arithmetic unit: add, subtract, multiply, divide, compare on
// two signed fractions, arithmetic results reduced by their greatest common divisor.
// Input channel: in_valid/in_ready with kind, a_num, a_den, b_num, b_den.
// Output channel: out_valid/out_ready with res_num, res_den, order, status.
// One item at a time: in_ready is high only while idle.
// A zero input denominator is reported straight from the first multiply
// state; compare or a zero divisor after the product and sum states; for
// arithmetic the binary gcd loop runs (one shift or subtract each step),
// then two restoring divisions, numerator and then denominator.
// A new item enters only after the last result beat is taken.
// The shared 32x32 multiplier and the one-bit-a-cycle divider set the pace.
// The result beat is held until out_ready; no new item enters meanwhile.
// Reset (arst_n low) returns the sequencer to idle with no beat pending.
// Status: 0 ok, 1 divide by zero, 2 overflow.
// depends on rau_pkg, rau_ctrl, rau_dp
module rational_arith_unit_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [2:0]                            kind,
	input  logic signed [rau_pkg::WORD_WIDTH-1:0] a_num,
	input  logic signed [rau_pkg::WORD_WIDTH-1:0] a_den,
	input  logic signed [rau_pkg::WORD_WIDTH-1:0] b_num,
	input  logic signed [rau_pkg::WORD_WIDTH-1:0] b_den,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [rau_pkg::WORD_WIDTH-1:0] res_num,
	output logic [rau_pkg::WORD_WIDTH-2:0]        res_den,
	output logic signed [1:0]                     order,
	output logic [1:0]                            status
);
	import rau_pkg::*;

	cmd_t cmd;
	sts_t sts;

	rau_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .sts(sts), .cmd(cmd)
	);

	rau_dp u_dp (
		.clk(clk), .cmd(cmd), .sts(sts), .kind(kind),
		.a_num(a_num), .a_den(a_den), .b_num(b_num), .b_den(b_den),
		.res_num(res_num), .res_den(res_den), .order(order), .status(status)
	);

`ifndef SYNTHESIS
	// never ready for input while a result beat is pending
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("ready while result pending");
	// a stalled result beat keeps its status and numerator
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(status) && $stable(res_num))
		else $error("result changed under stall");
	// an ok result with a nonzero numerator has a nonzero denominator
	a_den_nz: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_OK && order == 2'b00 && res_num != '0 |->
		res_den != '0) else $error("zero denominator on ok result");
`endif
endmodule
